FILE: hdl/bxq_pkg.sv
// Shared types and constants for the box table point query block.
// No dependencies; every other file imports this package.
`default_nettype none

package bxq_pkg;

    localparam int IDX_W      = 6;
    localparam int DIST_W     = 26;
    localparam int ROOT_IN_W  = 2 * DIST_W;
    localparam int RES_W      = 1 + IDX_W + DIST_W + 1;
    localparam int RES_PAD_W  = ((RES_W + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OUT_ZERO  = 2'd0,
        OUT_FULL  = 2'd1,
        OUT_QUERY = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic      wr_en;
        logic      pt_load;
        logic      rd_en;
        logic      root_start;
        logic      out_load;
        out_kind_t out_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic root_busy;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/box_table_point_query.sv
// Box table point query: append/query/clear beats, one result beat per input beat.
// Append, clear and unused modes: result beat in the cycle after the input beat.
// Query: one box per cycle from the memory read port, a 4-stage distance pipe, then the
// iterative square root before the result beat.
// One item in flight; the next input beat can be taken with the result beat. Async rst_n
// empties the table.
// Depends on bxq_pkg, bxq_ctrl, bxq_dp, bxq_isqrt.
`default_nettype none

module box_table_point_query
    import bxq_pkg::*;
#(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 24,
    localparam int IN_W      = 1 + 9 * COORD_BITS,
    localparam int IN_PAD_W  = ((IN_W + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, pt_x, pt_y, pt_z
    input  logic [IN_PAD_W-1:0]  s_tdata,
    // mode
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // found, box_index, min_dist, table_full
    output logic [RES_PAD_W-1:0] m_tdata
);

    localparam int CB = COORD_BITS;
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [AW-1:0] mem_addr;

    logic              found;
    logic [IDX_W-1:0]  box_index;
    logic [DIST_W-1:0] min_dist;
    logic              table_full;

    bxq_ctrl #(
        .MAX_BOXES (MAX_BOXES),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .mode      (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .mem_addr  (mem_addr),
        .status    (status)
    );

    bxq_dp #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mem_addr    (mem_addr),
        .entry_valid (s_tdata[0]),
        .lo_x        (s_tdata[1 + 0*CB +: CB]),
        .lo_y        (s_tdata[1 + 1*CB +: CB]),
        .lo_z        (s_tdata[1 + 2*CB +: CB]),
        .hi_x        (s_tdata[1 + 3*CB +: CB]),
        .hi_y        (s_tdata[1 + 4*CB +: CB]),
        .hi_z        (s_tdata[1 + 5*CB +: CB]),
        .pt_x        (s_tdata[1 + 6*CB +: CB]),
        .pt_y        (s_tdata[1 + 7*CB +: CB]),
        .pt_z        (s_tdata[1 + 8*CB +: CB]),
        .status      (status),
        .found       (found),
        .box_index   (box_index),
        .min_dist    (min_dist),
        .table_full  (table_full)
    );

    assign m_tdata = RES_PAD_W'({table_full, min_dist, box_index, found});

endmodule

`default_nettype wire

FILE: hdl/bxq_isqrt.sv
// Iterative integer square root, two root bits per cycle.
// Depends on bxq_pkg for the operand and root widths.
`default_nettype none

module bxq_isqrt
    import bxq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ROOT_IN_W-1:0] operand,
    output logic                 busy,
    output logic [DIST_W-1:0]    root
);

    localparam int REM_W = DIST_W + 3;
    localparam int STEPS = DIST_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [ROOT_IN_W-1:0] op_reg, op_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DIST_W-1:0]    root_reg, root_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;

    always_comb
    begin
        logic [REM_W-1:0]     r;
        logic [DIST_W-1:0]    q;
        logic [ROOT_IN_W-1:0] o;
        logic [REM_W-1:0]     trial;
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        r     = rem_reg;
        q     = root_reg;
        o     = op_reg;
        trial = '0;
        if (start)
        begin
            op_next   = operand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // restoring digit recurrence: bring down two operand bits per root bit
            for (int k = 0; k < 2; k++)
            begin
                r     = {r[REM_W-3:0], o[ROOT_IN_W-1 -: 2]};
                o     = o << 2;
                trial = REM_W'({q, 2'b01});
                if (r >= trial)
                begin
                    r = r - trial;
                    q = {q[DIST_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[DIST_W-2:0], 1'b0};
                end
            end
            op_next   = o;
            rem_next  = r;
            root_next = q;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

FILE: hdl/bxq_dp.sv
// Datapath: box memory, per-box distance pipeline, running minimum, result register.
// Depends on bxq_pkg and bxq_isqrt.
`default_nettype none

module bxq_dp
    import bxq_pkg::*;
#(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 24,
    parameter int AW         = 6
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    input  logic [AW-1:0]                mem_addr,
    input  logic                         entry_valid,
    input  logic signed [COORD_BITS-1:0] lo_x,
    input  logic signed [COORD_BITS-1:0] lo_y,
    input  logic signed [COORD_BITS-1:0] lo_z,
    input  logic signed [COORD_BITS-1:0] hi_x,
    input  logic signed [COORD_BITS-1:0] hi_y,
    input  logic signed [COORD_BITS-1:0] hi_z,
    input  logic signed [COORD_BITS-1:0] pt_x,
    input  logic signed [COORD_BITS-1:0] pt_y,
    input  logic signed [COORD_BITS-1:0] pt_z,
    output dp_status_t                   status,
    output logic                         found,
    output logic [IDX_W-1:0]             box_index,
    output logic [DIST_W-1:0]            min_dist,
    output logic                         table_full
);

    localparam int CB      = COORD_BITS;
    localparam int BOX_W   = 1 + 6 * CB;
    localparam int SQ_W    = 2 * CB;
    localparam int SUM_W   = SQ_W + 2;
    localparam int CLAMP_W = ROOT_IN_W + 1;
    localparam int EXT_W   = (SUM_W > CLAMP_W) ? SUM_W : CLAMP_W;

    function automatic logic [CB-1:0] axis_gap(input logic signed [CB-1:0] p,
                                               input logic signed [CB-1:0] lo,
                                               input logic signed [CB-1:0] hi);
        logic [CB:0] d;
        if (p < lo)
        begin
            d = {lo[CB-1], lo} - {p[CB-1], p};
        end
        else if (p > hi)
        begin
            d = {p[CB-1], p} - {hi[CB-1], hi};
        end
        else
        begin
            d = '0;
        end
        return d[CB-1:0];
    endfunction

    logic [BOX_W-1:0] mem [MAX_BOXES];
    logic [BOX_W-1:0] rd_word_reg;

    logic signed [CB-1:0] px_reg, py_reg, pz_reg;

    // stage 0: memory read
    logic          v0_reg;
    logic [AW-1:0] idx0_reg;
    // stage 1: gaps and containment
    logic          v1_reg, in1_reg;
    logic [AW-1:0] idx1_reg;
    logic [CB-1:0] gx1_reg, gy1_reg, gz1_reg;
    // stage 2: squares
    logic            v2_reg, in2_reg;
    logic [AW-1:0]   idx2_reg;
    logic [SQ_W-1:0] sx2_reg, sy2_reg, sz2_reg;
    // stage 3: clamped sum
    logic               v3_reg, in3_reg;
    logic [AW-1:0]      idx3_reg;
    logic [CLAMP_W-1:0] s3_reg;
    // running result of the scan
    logic               any_reg, hit_reg;
    logic [AW-1:0]      hit_idx_reg;
    logic [CLAMP_W-1:0] best_reg;

    logic                 b_valid;
    logic signed [CB-1:0] b_lox, b_loy, b_loz, b_hix, b_hiy, b_hiz;
    logic                 b_in;
    logic [SUM_W-1:0]     sum3;
    logic [EXT_W-1:0]     sum_ext;
    logic [CLAMP_W-1:0]   sum_clamp;

    logic [DIST_W-1:0] root;
    logic              root_busy;

    logic             found_reg, full_reg;
    logic [IDX_W-1:0] index_reg;
    logic [DIST_W-1:0] dist_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[mem_addr] <= {hi_z, hi_y, hi_x, lo_z, lo_y, lo_x, entry_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_word_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        b_valid = rd_word_reg[0];
        b_lox   = rd_word_reg[1 + 0*CB +: CB];
        b_loy   = rd_word_reg[1 + 1*CB +: CB];
        b_loz   = rd_word_reg[1 + 2*CB +: CB];
        b_hix   = rd_word_reg[1 + 3*CB +: CB];
        b_hiy   = rd_word_reg[1 + 4*CB +: CB];
        b_hiz   = rd_word_reg[1 + 5*CB +: CB];
        b_in    = (px_reg >= b_lox) && (px_reg <= b_hix) &&
                  (py_reg >= b_loy) && (py_reg <= b_hiy) &&
                  (pz_reg >= b_loz) && (pz_reg <= b_hiz);
    end

    // anything at or above 2^52 gives a root past the distance range
    always_comb
    begin
        sum3    = SUM_W'(sx2_reg) + SUM_W'(sy2_reg) + SUM_W'(sz2_reg);
        sum_ext = EXT_W'(sum3);
        if (sum_ext >= (EXT_W'(1) << ROOT_IN_W))
        begin
            sum_clamp = CLAMP_W'(1) << ROOT_IN_W;
        end
        else
        begin
            sum_clamp = sum_ext[CLAMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= cmd.rd_en;
            v1_reg <= v0_reg && b_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pt_load)
        begin
            px_reg <= pt_x;
            py_reg <= pt_y;
            pz_reg <= pt_z;
        end
        idx0_reg <= mem_addr;
        idx1_reg <= idx0_reg;
        in1_reg  <= b_in;
        gx1_reg  <= axis_gap(px_reg, b_lox, b_hix);
        gy1_reg  <= axis_gap(py_reg, b_loy, b_hiy);
        gz1_reg  <= axis_gap(pz_reg, b_loz, b_hiz);
        idx2_reg <= idx1_reg;
        in2_reg  <= in1_reg;
        sx2_reg  <= gx1_reg * gx1_reg;
        sy2_reg  <= gy1_reg * gy1_reg;
        sz2_reg  <= gz1_reg * gz1_reg;
        idx3_reg <= idx2_reg;
        in3_reg  <= in2_reg;
        s3_reg   <= sum_clamp;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pt_load)
        begin
            any_reg     <= 1'b0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
        end
        else if (v3_reg)
        begin
            if (!any_reg || (s3_reg < best_reg))
            begin
                best_reg <= s3_reg;
            end
            any_reg <= 1'b1;
            // boxes arrive in index order, so the first hit is the lowest index
            if (in3_reg && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx3_reg;
            end
        end
    end

    bxq_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.root_start),
        .operand (best_reg[ROOT_IN_W-1:0]),
        .busy    (root_busy),
        .root    (root)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_kind)
                OUT_QUERY:
                begin
                    found_reg <= hit_reg;
                    index_reg <= IDX_W'(hit_idx_reg);
                    dist_reg  <= (!any_reg || best_reg[ROOT_IN_W]) ? DIST_MAX : root;
                    full_reg  <= 1'b0;
                end
                OUT_FULL:
                begin
                    found_reg <= 1'b0;
                    index_reg <= '0;
                    dist_reg  <= '0;
                    full_reg  <= 1'b1;
                end
                default:
                begin
                    found_reg <= 1'b0;
                    index_reg <= '0;
                    dist_reg  <= '0;
                    full_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign status.pipe_busy = v0_reg || v1_reg || v2_reg || v3_reg;
    assign status.root_busy = root_busy;

    assign found      = found_reg;
    assign box_index  = index_reg;
    assign min_dist   = dist_reg;
    assign table_full = full_reg;

endmodule

`default_nettype wire

FILE: hdl/bxq_ctrl.sv
// Controller: handshakes, box count, scan sequencing and result valid.
// Depends on bxq_pkg; drives bxq_dp through dp_cmd_t.
`default_nettype none

module bxq_ctrl
    import bxq_pkg::*;
#(
    parameter int MAX_BOXES = 64,
    parameter int AW        = 6,
    parameter int CW        = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    mode,
    output logic          out_valid,
    input  logic          out_ready,
    output dp_cmd_t       cmd,
    output logic [AW-1:0] mem_addr,
    input  dp_status_t    status
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_ROOT  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BOXES);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          out_valid_reg, out_valid_next;
    logic          slot_free;
    logic          accept;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        cmd        = '0;
        mem_addr   = count_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_APPEND:
                        begin
                            cmd.out_load = 1'b1;
                            if (count_reg == COUNT_MAX)
                            begin
                                cmd.out_kind = OUT_FULL;
                            end
                            else
                            begin
                                cmd.wr_en    = 1'b1;
                                cmd.out_kind = OUT_ZERO;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        MODE_QUERY:
                        begin
                            cmd.pt_load = 1'b1;
                            scan_next   = '0;
                            state_next  = S_SCAN;
                        end
                        MODE_CLEAR:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = OUT_ZERO;
                            count_next   = '0;
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = OUT_ZERO;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mem_addr = scan_reg[AW-1:0];
                if (scan_reg == count_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.root_start = 1'b1;
                    state_next     = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (!status.root_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_QUERY;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> slot_free)
        else $error("result loaded over a beat not yet taken");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("box count beyond table depth");

    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (scan_reg < count_reg))
        else $error("scan read past the filled part of the table");

    a_query_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_QUERY)) |=> (state_reg == S_SCAN))
        else $error("query beat did not start a scan");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (status.root_busy || status.pipe_busy) |-> !in_ready)
        else $error("input taken while a query is in flight");
`endif

endmodule

`default_nettype wire
